/* sv/rapc_pkg.sv */
// shared types and constants for the rogue access point classifier
package rapc_pkg;

   localparam logic [2:0] SEC_UNKNOWN = 3'd0;
   localparam logic [2:0] SEC_OPEN    = 3'd1;
   localparam logic [2:0] SEC_TOP     = 3'd6;

   localparam logic [2:0] VERDICT_NONE      = 3'd0;
   localparam logic [2:0] VERDICT_NEW_RADIO = 3'd1;
   localparam logic [2:0] VERDICT_DOWNGRADE = 3'd2;
   localparam logic [2:0] VERDICT_OPEN_TWIN = 3'd3;
   localparam logic [2:0] VERDICT_CHANNEL   = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RSCAN,
      ST_RWAIT,
      ST_NSCAN,
      ST_NWAIT,
      ST_LSCAN,
      ST_LWAIT,
      ST_FINISH,
      ST_OUT
   } state_type;

endpackage

/* sv/rogue_access_point_classifier.sv */
// top level of the rogue access point classifier
//
// one beacon sighting enters on the req_ channel per beat, one verdict leaves
// on the rsp_ channel per sighting. the radio table, name table and per-name
// radio lists sit in synchronous memories with registered reads.
// an item walks them one entry at a time: the radio table scan (skipped for
// channel zero), the name table scan (skipped for a hidden name), then the
// radio list of the matching name. each memory entry is read in one scan
// state and compared in the wait state that follows, as set by the single
// read port of each memory. one item is in flight at a time.
// reset clears the control state and the valid bits of both tables; the
// stored names, addresses and channels need no clearing since an entry is
// read only after it is claimed. the result is held in an output register
// until rsp_tready; while a result waits, req_tready stays low.
// a full table drops new entries silently; a full radio list still flags.
module rogue_access_point_classifier #(
   parameter int NAME_ENTRIES    = 16,
   parameter int RADIO_ENTRIES   = 64,
   parameter int RADIOS_PER_NAME = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // name_bytes_0_7, name_bytes_8_15, name_bytes_16_23, name_bytes_24_31,
   // radio_address, channel, security_mode; padded to 320 bits
   input  logic [319:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // verdict, detail, names_tracked, radios_tracked; padded to 24 bits
   output logic [23:0]  rsp_tdata
);

   localparam int NW = (NAME_ENTRIES > 1) ? $clog2(NAME_ENTRIES) : 1;
   localparam int RW = (RADIO_ENTRIES > 1) ? $clog2(RADIO_ENTRIES) : 1;
   localparam int LW = (RADIOS_PER_NAME > 1) ? $clog2(RADIOS_PER_NAME) : 1;
   localparam int LIW = (NAME_ENTRIES * RADIOS_PER_NAME > 1) ?
                        $clog2(NAME_ENTRIES * RADIOS_PER_NAME) : 1;
   localparam int NCW = $clog2(NAME_ENTRIES + 1);
   localparam int RCW = $clog2(RADIO_ENTRIES + 1);
   localparam int LCW = $clog2(RADIOS_PER_NAME + 1);

   // memories
   logic [255:0] name_mem [NAME_ENTRIES];
   logic [2:0]   sec_mem [NAME_ENTRIES];
   logic [LCW-1:0] cnt_mem [NAME_ENTRIES];
   logic [47:0]  list_mem [NAME_ENTRIES * RADIOS_PER_NAME];
   logic [47:0]  mac_mem [RADIO_ENTRIES];
   logic [7:0]   chan_mem [RADIO_ENTRIES];

   logic [NAME_ENTRIES-1:0]  name_used_ff, name_used_in;
   logic [RADIO_ENTRIES-1:0] radio_used_ff, radio_used_in;
   logic [NCW-1:0] names_cnt_ff, names_cnt_in;
   logic [RCW-1:0] radios_cnt_ff, radios_cnt_in;

   rapc_pkg::state_type state_ff, state_in;

   // item registers
   logic [255:0] name_ff, name_in;
   logic [47:0]  mac_ff, mac_in;
   logic [7:0]   chan_ff, chan_in;
   logic [2:0]   sec_ff, sec_in;

   logic [RCW-1:0] ridx_ff, ridx_in;
   logic [NCW-1:0] nidx_ff, nidx_in;
   logic [LCW-1:0] lidx_ff, lidx_in;
   logic [NW-1:0]  nhit_ff, nhit_in;
   logic [2:0]     base_ff, base_in;
   logic [LCW-1:0] lcnt_ff, lcnt_in;

   logic [2:0] cflag_ff, cflag_in, nflag_ff, nflag_in;
   logic [7:0] cdet_ff, cdet_in, ndet_ff, ndet_in;

   logic [23:0] rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // read data registers
   logic [255:0] name_rd_ff;
   logic [2:0]   sec_rd_ff;
   logic [LCW-1:0] cnt_rd_ff;
   logic [47:0]  list_rd_ff, mac_rd_ff;
   logic [7:0]   chan_rd_ff;

   // write controls
   logic           mac_we, chan_we, name_we, sec_we, cnt_we, list_we;
   logic [RW-1:0]  r_waddr;
   logic [NW-1:0]  n_waddr;
   logic [LW-1:0]  l_wslot;
   logic [LIW-1:0] l_waddr;
   logic [2:0]     sec_wdata;
   logic [LCW-1:0] cnt_wdata;
   logic [7:0]     chan_wdata;

   // read addresses
   logic [RW-1:0]  r_raddr;
   logic [NW-1:0]  n_raddr;
   logic [LW-1:0]  l_rslot;
   logic [LIW-1:0] l_raddr;

   // canonical name: clear bytes after the first zero byte
   logic [255:0] canon;
   logic [2:0]   sec_raw;
   always_comb begin
      logic ended;
      ended = 1'b0;
      canon = '0;
      for (int b = 0; b < 32; b++) begin
         if (req_tdata[8*b +: 8] == 8'd0) ended = 1'b1;
         if (!ended) canon[8*b +: 8] = req_tdata[8*b +: 8];
      end
      sec_raw = req_tdata[314:312];
   end

   // first free entries
   logic [RW-1:0] rfree;
   logic          rfree_ok;
   logic [NW-1:0] nfree;
   logic          nfree_ok;
   always_comb begin
      rfree = '0;
      rfree_ok = 1'b0;
      for (int i = RADIO_ENTRIES - 1; i >= 0; i--) begin
         if (!radio_used_ff[i]) begin
            rfree = RW'(i);
            rfree_ok = 1'b1;
         end
      end
      nfree = '0;
      nfree_ok = 1'b0;
      for (int i = NAME_ENTRIES - 1; i >= 0; i--) begin
         if (!name_used_ff[i]) begin
            nfree = NW'(i);
            nfree_ok = 1'b1;
         end
      end
   end

   assign r_raddr = ridx_ff[RW-1:0];
   assign n_raddr = nidx_ff[NW-1:0];
   assign l_rslot = lidx_ff[LW-1:0];
   assign l_raddr = LIW'(nhit_ff * RADIOS_PER_NAME + l_rslot);
   assign l_waddr = LIW'(n_waddr * RADIOS_PER_NAME + l_wslot);

   always_ff @(posedge clock) begin
      mac_rd_ff  <= mac_mem[r_raddr];
      chan_rd_ff <= chan_mem[r_raddr];
      name_rd_ff <= name_mem[n_raddr];
      sec_rd_ff  <= sec_mem[(state_ff == rapc_pkg::ST_NSCAN) ? n_raddr : nhit_ff];
      cnt_rd_ff  <= cnt_mem[(state_ff == rapc_pkg::ST_NSCAN) ? n_raddr : nhit_ff];
      list_rd_ff <= list_mem[l_raddr];
      if (mac_we) mac_mem[r_waddr] <= mac_ff;
      if (chan_we) chan_mem[r_waddr] <= chan_wdata;
      if (name_we) name_mem[n_waddr] <= name_ff;
      if (sec_we) sec_mem[n_waddr] <= sec_wdata;
      if (cnt_we) cnt_mem[n_waddr] <= cnt_wdata;
      if (list_we) list_mem[l_waddr] <= mac_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rapc_pkg::ST_IDLE;
         name_used_ff  <= '0;
         radio_used_ff <= '0;
         names_cnt_ff  <= '0;
         radios_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         name_used_ff  <= name_used_in;
         radio_used_ff <= radio_used_in;
         names_cnt_ff  <= names_cnt_in;
         radios_cnt_ff <= radios_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      name_ff  <= name_in;
      mac_ff   <= mac_in;
      chan_ff  <= chan_in;
      sec_ff   <= sec_in;
      ridx_ff  <= ridx_in;
      nidx_ff  <= nidx_in;
      lidx_ff  <= lidx_in;
      nhit_ff  <= nhit_in;
      base_ff  <= base_in;
      lcnt_ff  <= lcnt_in;
      cflag_ff <= cflag_in;
      cdet_ff  <= cdet_in;
      nflag_ff <= nflag_in;
      ndet_ff  <= ndet_in;
      rsp_ff   <= rsp_in;
   end

   logic [RW-1:0] rcur;
   logic [NW-1:0] ncur;
   assign rcur = r_raddr;
   assign ncur = n_raddr;

   always_comb begin
      state_in      = state_ff;
      name_used_in  = name_used_ff;
      radio_used_in = radio_used_ff;
      names_cnt_in  = names_cnt_ff;
      radios_cnt_in = radios_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      name_in  = name_ff;
      mac_in   = mac_ff;
      chan_in  = chan_ff;
      sec_in   = sec_ff;
      ridx_in  = ridx_ff;
      nidx_in  = nidx_ff;
      lidx_in  = lidx_ff;
      nhit_in  = nhit_ff;
      base_in  = base_ff;
      lcnt_in  = lcnt_ff;
      cflag_in = cflag_ff;
      cdet_in  = cdet_ff;
      nflag_in = nflag_ff;
      ndet_in  = ndet_ff;
      rsp_in   = rsp_ff;
      mac_we = 1'b0;
      chan_we = 1'b0;
      name_we = 1'b0;
      sec_we = 1'b0;
      cnt_we = 1'b0;
      list_we = 1'b0;
      r_waddr = rcur;
      n_waddr = nhit_ff;
      l_wslot = lcnt_ff[LW-1:0];
      sec_wdata = sec_ff;
      cnt_wdata = LCW'(1);
      chan_wdata = chan_ff;
      req_tready = 1'b0;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         rapc_pkg::ST_IDLE: begin
            req_tready = !rsp_valid_ff;
            if (req_tvalid && !rsp_valid_ff) begin
               name_in  = canon;
               mac_in   = req_tdata[303:256];
               chan_in  = req_tdata[311:304];
               sec_in   = (sec_raw > rapc_pkg::SEC_TOP) ? rapc_pkg::SEC_UNKNOWN : sec_raw;
               ridx_in  = '0;
               nidx_in  = '0;
               cflag_in = rapc_pkg::VERDICT_NONE;
               cdet_in  = '0;
               nflag_in = rapc_pkg::VERDICT_NONE;
               ndet_in  = '0;
               state_in = (req_tdata[311:304] != 8'd0) ? rapc_pkg::ST_RSCAN
                                                      : rapc_pkg::ST_NSCAN;
            end
         end
         rapc_pkg::ST_RSCAN: begin
            // read address presented; compare next cycle
            state_in = rapc_pkg::ST_RWAIT;
         end
         rapc_pkg::ST_RWAIT: begin
            if (radio_used_ff[rcur] && mac_rd_ff == mac_ff) begin
               if (chan_rd_ff != chan_ff) begin
                  cflag_in = rapc_pkg::VERDICT_CHANNEL;
                  cdet_in  = chan_rd_ff;
                  chan_we  = 1'b1;
               end
               state_in = rapc_pkg::ST_NSCAN;
            end else if (ridx_ff == RCW'(RADIO_ENTRIES - 1)) begin
               if (rfree_ok) begin
                  r_waddr = rfree;
                  mac_we  = 1'b1;
                  chan_we = 1'b1;
                  radio_used_in[rfree] = 1'b1;
                  radios_cnt_in = radios_cnt_ff + RCW'(1);
               end
               state_in = rapc_pkg::ST_NSCAN;
            end else begin
               ridx_in  = ridx_ff + RCW'(1);
               state_in = rapc_pkg::ST_RSCAN;
            end
            if (state_in == rapc_pkg::ST_NSCAN && name_ff[7:0] == 8'd0)
               state_in = rapc_pkg::ST_FINISH;
         end
         rapc_pkg::ST_NSCAN: begin
            if (name_ff[7:0] == 8'd0) state_in = rapc_pkg::ST_FINISH;
            else state_in = rapc_pkg::ST_NWAIT;
         end
         rapc_pkg::ST_NWAIT: begin
            if (name_used_ff[ncur] && name_rd_ff == name_ff) begin
               nhit_in = ncur;
               base_in = sec_rd_ff;
               lcnt_in = (cnt_rd_ff > LCW'(RADIOS_PER_NAME)) ? LCW'(RADIOS_PER_NAME)
                                                              : cnt_rd_ff;
               if (sec_ff != rapc_pkg::SEC_UNKNOWN && sec_rd_ff != rapc_pkg::SEC_UNKNOWN
                   && sec_ff < sec_rd_ff) begin
                  nflag_in = (sec_ff == rapc_pkg::SEC_OPEN) ? rapc_pkg::VERDICT_OPEN_TWIN
                                                            : rapc_pkg::VERDICT_DOWNGRADE;
                  ndet_in  = {5'd0, sec_rd_ff};
               end
               lidx_in  = '0;
               state_in = rapc_pkg::ST_LSCAN;
            end else if (nidx_ff == NCW'(NAME_ENTRIES - 1)) begin
               if (nfree_ok) begin
                  n_waddr = nfree;
                  name_we = 1'b1;
                  sec_we  = 1'b1;
                  cnt_we  = 1'b1;
                  list_we = 1'b1;
                  l_wslot = '0;
                  name_used_in[nfree] = 1'b1;
                  names_cnt_in = names_cnt_ff + NCW'(1);
               end
               state_in = rapc_pkg::ST_FINISH;
            end else begin
               nidx_in  = nidx_ff + NCW'(1);
               state_in = rapc_pkg::ST_NSCAN;
            end
         end
         rapc_pkg::ST_LSCAN: begin
            if (lidx_ff == lcnt_ff) begin
               // radio not in the list
               if (nflag_ff == rapc_pkg::VERDICT_NONE) begin
                  nflag_in = rapc_pkg::VERDICT_NEW_RADIO;
                  ndet_in  = 8'(lcnt_ff);
               end
               if (lcnt_ff < LCW'(RADIOS_PER_NAME)) begin
                  list_we   = 1'b1;
                  cnt_we    = 1'b1;
                  cnt_wdata = lcnt_ff + LCW'(1);
               end
               if (sec_ff > base_ff) sec_we = 1'b1;
               state_in = rapc_pkg::ST_FINISH;
            end else begin
               state_in = rapc_pkg::ST_LWAIT;
            end
         end
         rapc_pkg::ST_LWAIT: begin
            if (list_rd_ff == mac_ff) begin
               if (sec_ff > base_ff) sec_we = 1'b1;
               state_in = rapc_pkg::ST_FINISH;
            end else begin
               lidx_in  = lidx_ff + LCW'(1);
               state_in = rapc_pkg::ST_LSCAN;
            end
         end
         rapc_pkg::ST_FINISH: begin
            rsp_in[2:0]  = (nflag_ff != rapc_pkg::VERDICT_NONE) ? nflag_ff : cflag_ff;
            rsp_in[10:3] = (nflag_ff != rapc_pkg::VERDICT_NONE) ? ndet_ff : cdet_ff;
            rsp_in[15:11] = 5'(names_cnt_ff);
            rsp_in[22:16] = 7'(radios_cnt_ff);
            rsp_in[23]    = 1'b0;
            rsp_valid_in  = 1'b1;
            state_in = rapc_pkg::ST_OUT;
         end
         rapc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) state_in = rapc_pkg::ST_IDLE;
         end
         default: state_in = rapc_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

/* tb/tb_rogue_access_point_classifier.sv */
// self-checking testbench for the rogue access point classifier
`timescale 1ns / 100ps

module tb_rogue_access_point_classifier;

   localparam int NAMES_MAX   = 16;
   localparam int RADIOS_MAX  = 64;
   localparam int PER_NAME    = 8;
   localparam int LIMIT       = 2000000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [2:0]  sec;
      logic [7:0]  chan;
      logic [47:0] mac;
      logic [63:0] w3;
      logic [63:0] w2;
      logic [63:0] w1;
      logic [63:0] w0;
   } sighting_type;

   typedef struct packed {
      logic [6:0] radios;
      logic [4:0] names;
      logic [7:0] detail;
      logic [2:0] verdict;
   } verdict_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // name_bytes_0_7, name_bytes_8_15, name_bytes_16_23, name_bytes_24_31,
   // radio_address, channel, security_mode; padded to 320 bits
   logic [319:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // verdict, detail, names_tracked, radios_tracked; padded to 24 bits
   logic [23:0]  rsp_tdata;

   rogue_access_point_classifier dut (.*);

   // predictor state: a shadow of both tables
   logic        nm_used [NAMES_MAX];
   logic [255:0] nm_text [NAMES_MAX];
   logic [2:0]  nm_best [NAMES_MAX];
   int          nm_cnt [NAMES_MAX];
   logic [47:0] nm_list [NAMES_MAX][PER_NAME];
   logic        rd_used [RADIOS_MAX];
   logic [47:0] rd_mac [RADIOS_MAX];
   logic [7:0]  rd_chan [RADIOS_MAX];

   sighting_type pending_sightings [$];
   verdict_type  expected_verdicts [$];

   int errors = 0;
   int cycles = 0;
   int accepted = 0;
   int checked = 0;
   int flagged [5];
   int send_idle_pct = 18;
   int recv_idle_pct = 61;
   bit hold_go = 0;
   int hold_left = HOLD_CYCLES;

   // name pool and radio pool so random traffic revisits known entries
   logic [255:0] name_pool [24];
   logic [47:0]  mac_pool [80];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch on beat %0d: %s got %0d expected %0d", checked, what, got, want);
   endtask

   // clear bytes after the first zero byte
   function automatic logic [255:0] canonical_name(input logic [255:0] raw);
      logic [255:0] o;
      bit ended;
      o = '0;
      ended = 0;
      for (int b = 0; b < 32; b++) begin
         if (raw[8*b +: 8] == 8'h00) ended = 1;
         if (!ended) o[8*b +: 8] = raw[8*b +: 8];
      end
      return o;
   endfunction

   function automatic verdict_type classify_sighting(input sighting_type s);
      verdict_type r;
      logic [255:0] nm;
      logic [2:0] sec, base;
      logic [2:0] chan_flag, name_flag;
      logic [7:0] chan_det, name_det;
      int hit, cnt, n_names, n_radios;
      bit known;
      sec = (s.sec > rapc_pkg::SEC_TOP) ? rapc_pkg::SEC_UNKNOWN : s.sec;
      nm = canonical_name({s.w3, s.w2, s.w1, s.w0});
      chan_flag = rapc_pkg::VERDICT_NONE;
      name_flag = rapc_pkg::VERDICT_NONE;
      chan_det = '0;
      name_det = '0;
      if (s.chan != 8'd0) begin
         hit = -1;
         for (int i = 0; i < RADIOS_MAX; i++)
            if (hit < 0 && rd_used[i] && rd_mac[i] == s.mac) hit = i;
         if (hit < 0) begin
            for (int i = 0; i < RADIOS_MAX; i++)
               if (hit < 0 && !rd_used[i]) begin
                  rd_used[i] = 1'b1;
                  rd_mac[i] = s.mac;
                  rd_chan[i] = s.chan;
                  hit = i;
               end
         end else if (rd_chan[hit] != s.chan) begin
            chan_flag = rapc_pkg::VERDICT_CHANNEL;
            chan_det = rd_chan[hit];
            rd_chan[hit] = s.chan;
         end
      end
      if (nm[7:0] != 8'h00) begin
         hit = -1;
         for (int i = 0; i < NAMES_MAX; i++)
            if (hit < 0 && nm_used[i] && nm_text[i] == nm) hit = i;
         if (hit < 0) begin
            for (int i = 0; i < NAMES_MAX; i++)
               if (hit < 0 && !nm_used[i]) begin
                  nm_used[i] = 1'b1;
                  nm_text[i] = nm;
                  nm_best[i] = sec;
                  nm_cnt[i] = 1;
                  nm_list[i][0] = s.mac;
                  hit = i;
               end
         end else begin
            base = nm_best[hit];
            cnt = (nm_cnt[hit] > PER_NAME) ? PER_NAME : nm_cnt[hit];
            if (sec != rapc_pkg::SEC_UNKNOWN && base != rapc_pkg::SEC_UNKNOWN && sec < base)
            begin
               name_flag = (sec == rapc_pkg::SEC_OPEN) ? rapc_pkg::VERDICT_OPEN_TWIN
                                                       : rapc_pkg::VERDICT_DOWNGRADE;
               name_det = {5'd0, base};
            end
            known = 0;
            for (int i = 0; i < cnt; i++) if (nm_list[hit][i] == s.mac) known = 1;
            if (!known) begin
               if (name_flag == rapc_pkg::VERDICT_NONE) begin
                  name_flag = rapc_pkg::VERDICT_NEW_RADIO;
                  name_det = cnt[7:0];
               end
               if (cnt < PER_NAME) begin
                  nm_list[hit][cnt] = s.mac;
                  nm_cnt[hit] = cnt + 1;
               end
            end
            if (sec > base) nm_best[hit] = sec;
         end
      end
      n_names = 0;
      n_radios = 0;
      foreach (nm_used[i]) if (nm_used[i]) n_names++;
      foreach (rd_used[i]) if (rd_used[i]) n_radios++;
      r.verdict = (name_flag != rapc_pkg::VERDICT_NONE) ? name_flag : chan_flag;
      r.detail = (name_flag != rapc_pkg::VERDICT_NONE) ? name_det : chan_det;
      r.names = n_names[4:0];
      r.radios = n_radios[6:0];
      return r;
   endfunction

   function automatic sighting_type make_sighting(input logic [255:0] nm,
                                                  input logic [47:0] mac,
                                                  input logic [7:0] chan,
                                                  input logic [2:0] sec);
      sighting_type s;
      {s.w3, s.w2, s.w1, s.w0} = nm;
      s.mac = mac;
      s.chan = chan;
      s.sec = sec;
      return s;
   endfunction

   // name of nonzero bytes, 1..12 or 32 long, optionally with junk after a terminator
   function automatic logic [255:0] random_name(input bit junk_tail);
      logic [255:0] n;
      int len;
      n = '0;
      len = ($urandom_range(0, 5) == 0) ? 32 : int'($urandom_range(1, 12));
      for (int b = 0; b < len; b++) n[8*b +: 8] = 8'($urandom_range(1, 255));
      if (junk_tail && len < 31)
         for (int b = len + 1; b < 32; b++) n[8*b +: 8] = 8'($urandom_range(0, 255));
      return n;
   endfunction

   // driver: offers queued sightings, idles at random
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         cycles++;
         if (req_tvalid && req_tready) begin
            expected_verdicts.push_back(
               classify_sighting(sighting_type'(req_tdata[$bits(sighting_type)-1:0])));
            accepted++;
         end
         if ((req_tvalid && !req_tready)) begin
            // hold the beat until it is taken
         end else if (pending_sightings.size() > 0 &&
                      $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= {{(320 - $bits(sighting_type)){1'b0}}, pending_sightings.pop_front()};
         end else begin
            req_tvalid <= 1'b0;
         end
         if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // receiver hold-off: counts down its own cycles once started
   always @(posedge clock) begin
      if (hold_go && hold_left > 0) hold_left <= hold_left - 1;
   end

   // monitor: checks every accepted result against the oldest expectation
   always @(posedge clock) begin
      verdict_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = verdict_type'(rsp_tdata[$bits(verdict_type)-1:0]);
            checked++;
            if (expected_verdicts.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_verdicts.pop_front();
               flagged[want.verdict]++;
               if (got.verdict !== want.verdict)
                  report_mismatch("verdict", int'(got.verdict), int'(want.verdict));
               if (got.detail !== want.detail)
                  report_mismatch("detail", int'(got.detail), int'(want.detail));
               if (got.names !== want.names)
                  report_mismatch("names", int'(got.names), int'(want.names));
               if (got.radios !== want.radios)
                  report_mismatch("radios", int'(got.radios), int'(want.radios));
            end
         end
         if (hold_go && hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // sampled at the falling edge so every driver update has settled
   task automatic wait_drained();
      while (pending_sightings.size() > 0 || req_tvalid || expected_verdicts.size() > 0)
         @(negedge clock);
   endtask

   task automatic random_phase(input int count);
      int pick;
      logic [2:0] sec;
      logic [7:0] chan;
      for (int k = 0; k < count; k++) begin
         pick = int'($urandom_range(0, 99));
         sec = 3'($urandom_range(0, 7));
         chan = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 14));
         if (pick < 8) chan = 8'($urandom_range(0, 255));
         if (pick < 80)
            pending_sightings.push_back(make_sighting(name_pool[$urandom_range(0, 23)],
               mac_pool[$urandom_range(0, 79)], chan, sec));
         else if (pick < 90)
            pending_sightings.push_back(make_sighting(random_name(1),
               48'({$urandom, $urandom}), chan, sec));
         else
            pending_sightings.push_back(make_sighting({$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom}, 48'({$urandom, $urandom}), chan, sec));
      end
   endtask

   initial begin
      logic [255:0] home;
      logic [47:0] ap;
      clock = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      reset = 1'b1;
      foreach (nm_used[i]) nm_used[i] = 1'b0;
      foreach (rd_used[i]) rd_used[i] = 1'b0;
      foreach (flagged[i]) flagged[i] = 0;
      foreach (name_pool[i]) name_pool[i] = random_name(1'($urandom_range(0, 1)));
      foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
      mac_pool[0] = '0;
      mac_pool[1] = '1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: baseline, channel change, downgrade, open twin, new radio, precedence
      home = {{248{1'b0}}, 8'h41} | (256'h4e_4f_48 << 8);
      ap = 48'h0a0b0c0d0e0f;
      pending_sightings.push_back(make_sighting(home, ap, 8'd6, 3'd5));
      pending_sightings.push_back(make_sighting(home, ap, 8'd11, 3'd5));
      pending_sightings.push_back(make_sighting(home, ap, 8'd11, 3'd4));
      pending_sightings.push_back(make_sighting(home, ap, 8'd1, 3'd1));
      pending_sightings.push_back(make_sighting(home, 48'h1, 8'd0, 3'd0));
      pending_sightings.push_back(make_sighting(home, 48'h2, 8'd255, 3'd7));
      pending_sightings.push_back(make_sighting(home | (256'hff << 80), ap, 8'd0, 3'd6));
      pending_sightings.push_back(make_sighting('0, '1, 8'd255, 3'd6));
      pending_sightings.push_back(make_sighting('1, '0, 8'd1, 3'd0));
      pending_sightings.push_back(make_sighting('1, '0, 8'd1, 3'd6));
      pending_sightings.push_back(make_sighting('1, '1, 8'd2, 3'd1));
      pending_sightings.push_back(make_sighting('1, '1, 8'd3, 3'd3));
      // overflow the radio list of one name
      for (int i = 3; i < 13; i++)
         pending_sightings.push_back(make_sighting(home, 48'(i), 8'd0, 3'd5));
      wait_drained();

      // fill the name and radio tables past capacity, with a long receiver hold-off
      hold_go = 1'b1;
      for (int i = 0; i < 90; i++)
         pending_sightings.push_back(make_sighting(random_name(0), {$urandom, 16'(i)},
            8'($urandom_range(1, 255)), 3'($urandom_range(0, 7))));
      random_phase(100);
      wait_drained();

      send_idle_pct = 61;
      recv_idle_pct = 18;
      random_phase(200);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(200);
      wait_drained();
      repeat (300) @(posedge clock);

      $display("%0d sightings sent, %0d checked: %0d quiet, %0d new radio, %0d downgrade,",
               accepted, checked, flagged[0], flagged[1], flagged[2]);
      $display("%0d open twin, %0d channel change; tables filled past capacity",
               flagged[3], flagged[4]);
      if (errors == 0 && expected_verdicts.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/rapc_pkg.sv
sv/rogue_access_point_classifier.sv
tb/tb_rogue_access_point_classifier.sv
